### hw/rtl/sfcb_pkg.sv
package sfcb_pkg;

  // Default geometry of a flash page and of one host read packet
  localparam int PAGE_BYTES_DEF  = 264;
  localparam int CHUNK_BYTES_DEF = 64;

  // Depth of the job queue between front and back
  localparam int QDEPTH = 4;

  // Number of configuration registers and their indexes
  localparam int NUM_REGS = 1;
  localparam logic REG_VERSION = 1'b0;

  // Job kinds handed from the front to the back
  localparam logic [3:0] J_HOST    = 4'd0;  // one host byte
  localparam logic [3:0] J_VERSION = 4'd1;  // seven-byte version reply
  localparam logic [3:0] J_WHDR    = 4'd2;  // buffer write header
  localparam logic [3:0] J_RHDR    = 4'd3;  // page read header with address
  localparam logic [3:0] J_ERASE   = 4'd4;  // erase sequence plus status poll
  localparam logic [3:0] J_PROG    = 4'd5;  // program with address plus status poll
  localparam logic [3:0] J_POLL    = 4'd6;  // status poll pair
  localparam logic [3:0] J_ID      = 4'd7;  // ID opcode and four dummy bytes
  localparam logic [3:0] J_WDATA   = 4'd8;  // one write data byte to flash
  localparam logic [3:0] J_RFIRST  = 4'd9;  // first dummy byte of a read chunk
  localparam logic [3:0] J_RMID    = 4'd10; // forward read byte, next dummy byte
  localparam logic [3:0] J_EXIT    = 4'd11; // exit request

  // Command opcodes from the host
  localparam logic [7:0] OPC_VERSION = 8'h00;
  localparam logic [7:0] OPC_ID      = 8'h01;
  localparam logic [7:0] OPC_WRITE   = 8'h02;
  localparam logic [7:0] OPC_READ    = 8'h03;
  localparam logic [7:0] OPC_ERASE   = 8'h04;
  localparam logic [7:0] OPC_STATUS  = 8'h05;
  localparam logic [7:0] OPC_BOOT    = 8'h24;
  localparam logic [7:0] OPC_NORMAL  = 8'hff;

  // Item codes on the input channel
  localparam logic [1:0] OP_HOST  = 2'd0;
  localparam logic [1:0] OP_FLASH = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Exit request codes
  localparam logic [1:0] EXIT_BOOT   = 2'd1;
  localparam logic [1:0] EXIT_NORMAL = 2'd2;

  // Flash opcodes and fixed bytes
  localparam logic [7:0] FL_BUF_WRITE = 8'h84;
  localparam logic [7:0] FL_PROGRAM   = 8'h83;
  localparam logic [7:0] FL_READ      = 8'h03;
  localparam logic [7:0] FL_STATUS    = 8'hd7;
  localparam logic [7:0] FL_ID        = 8'h9f;
  localparam logic [7:0] FL_DUMMY     = 8'hff;
  localparam logic [7:0] FL_ERASE0    = 8'hc7;
  localparam logic [7:0] FL_ERASE1    = 8'h94;
  localparam logic [7:0] FL_ERASE2    = 8'h80;
  localparam logic [7:0] FL_ERASE3    = 8'h9a;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  data;
    logic        rel;
    logic        pend;
    logic [23:0] addr;
  } job_t;

  typedef struct packed {
    logic       target;
    logic [7:0] out_byte;
    logic       select_release;
    logic       wants_reply;
    logic       packet_end;
    logic [1:0] exit_request;
    logic       last;
  } res_t;

  function automatic res_t mk_flash(logic [7:0] b, logic rel, logic want);
    res_t r;
    r = '0;
    r.target         = 1'b0;
    r.out_byte       = b;
    r.select_release = rel;
    r.wants_reply    = want;
    return r;
  endfunction

  function automatic res_t mk_host(logic [7:0] b, logic pend);
    res_t r;
    r = '0;
    r.target     = 1'b1;
    r.out_byte   = b;
    r.packet_end = pend;
    return r;
  endfunction

  // Result number idx of a job, with last set on its final result
  function automatic res_t job_result(job_t j, logic [2:0] idx);
    res_t r;
    r = '0;
    case (j.kind)
      J_HOST: begin
        r = mk_host(j.data, j.pend);
        r.last = 1'b1;
      end
      J_VERSION: begin
        case (idx)
          3'd0: r = mk_host(8'h48, 1'b0);
          3'd1: r = mk_host(8'h01, 1'b0);
          3'd2: r = mk_host(8'h46, 1'b0);
          3'd3: r = mk_host(8'h00, 1'b0);
          3'd4: r = mk_host(8'h01, 1'b0);
          3'd5: r = mk_host(8'h42, 1'b0);
          default: begin
            r = mk_host(j.data, 1'b1);
            r.last = 1'b1;
          end
        endcase
      end
      J_WHDR: begin
        case (idx)
          3'd0: r = mk_flash(FL_BUF_WRITE, 1'b0, 1'b0);
          3'd1: r = mk_flash(8'h00, 1'b0, 1'b0);
          3'd2: r = mk_flash(8'h00, 1'b0, 1'b0);
          default: begin
            r = mk_flash(8'h00, 1'b0, 1'b0);
            r.last = 1'b1;
          end
        endcase
      end
      J_RHDR: begin
        case (idx)
          3'd0: r = mk_flash(FL_READ, 1'b0, 1'b0);
          3'd1: r = mk_flash(j.addr[23:16], 1'b0, 1'b0);
          3'd2: r = mk_flash(j.addr[15:8], 1'b0, 1'b0);
          default: begin
            r = mk_flash(j.addr[7:0], 1'b0, 1'b0);
            r.last = 1'b1;
          end
        endcase
      end
      J_ERASE: begin
        case (idx)
          3'd0: r = mk_flash(FL_ERASE0, 1'b0, 1'b0);
          3'd1: r = mk_flash(FL_ERASE1, 1'b0, 1'b0);
          3'd2: r = mk_flash(FL_ERASE2, 1'b0, 1'b0);
          3'd3: r = mk_flash(FL_ERASE3, 1'b1, 1'b0);
          3'd4: r = mk_flash(FL_STATUS, 1'b0, 1'b0);
          default: begin
            r = mk_flash(FL_DUMMY, 1'b1, 1'b1);
            r.last = 1'b1;
          end
        endcase
      end
      J_PROG: begin
        case (idx)
          3'd0: r = mk_flash(FL_PROGRAM, 1'b0, 1'b0);
          3'd1: r = mk_flash(j.addr[23:16], 1'b0, 1'b0);
          3'd2: r = mk_flash(j.addr[15:8], 1'b0, 1'b0);
          3'd3: r = mk_flash(j.addr[7:0], 1'b1, 1'b0);
          3'd4: r = mk_flash(FL_STATUS, 1'b0, 1'b0);
          default: begin
            r = mk_flash(FL_DUMMY, 1'b1, 1'b1);
            r.last = 1'b1;
          end
        endcase
      end
      J_POLL: begin
        if (idx == 3'd0) begin
          r = mk_flash(FL_STATUS, 1'b0, 1'b0);
        end else begin
          r = mk_flash(FL_DUMMY, 1'b1, 1'b1);
          r.last = 1'b1;
        end
      end
      J_ID: begin
        case (idx)
          3'd0: r = mk_flash(FL_ID, 1'b0, 1'b0);
          3'd1: r = mk_flash(FL_DUMMY, 1'b0, 1'b1);
          3'd2: r = mk_flash(FL_DUMMY, 1'b0, 1'b1);
          3'd3: r = mk_flash(FL_DUMMY, 1'b0, 1'b1);
          default: begin
            r = mk_flash(FL_DUMMY, 1'b1, 1'b1);
            r.last = 1'b1;
          end
        endcase
      end
      J_WDATA: begin
        r = mk_flash(j.data, j.rel, 1'b0);
        r.last = 1'b1;
      end
      J_RFIRST: begin
        r = mk_flash(FL_DUMMY, j.rel, 1'b1);
        r.last = 1'b1;
      end
      J_RMID: begin
        if (idx == 3'd0) begin
          r = mk_host(j.data, 1'b0);
        end else begin
          r = mk_flash(FL_DUMMY, j.rel, 1'b1);
          r.last = 1'b1;
        end
      end
      J_EXIT: begin
        r.exit_request = j.data[1:0];
        r.last = 1'b1;
      end
      default: begin
        r.last = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/spi_flash_command_bridge.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   op, data
// output    out        out_valid / out_ready target, out_byte, select_release,
//                                            wants_reply, packet_end,
//                                            exit_request, last
// config    in/out     psel/penable/pready   paddr, pwdata, prdata
//
// An input item is taken whenever the four-entry job queue has room.
// Each job leaves as one to seven results from the output register, one per cycle unless the output stalls.
// Reset is synchronous and clears the command state, queue and output valid.
// A stalled output holds the back; the front keeps taking items until the queue fills.
module spi_flash_command_bridge import sfcb_pkg::*; #(
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        target,
  output logic [7:0]  out_byte,
  output logic        select_release,
  output logic        wants_reply,
  output logic        packet_end,
  output logic [1:0]  exit_request,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] version;
  logic       q_full;
  logic       push;
  job_t       push_job;
  logic       pop;
  logic       head_valid;
  job_t       head_job;
  res_t       out_res;
  logic       reg_hit;

  // Register file access
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_VERSION) && (paddr[1:0] == 2'd0);
  assign prdata  = reg_hit ? {24'd0, version} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      version <= 8'h00;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      version <= pwdata[7:0];
    end
  end

  sfcb_front #(
    .PAGE_BYTES  (PAGE_BYTES),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .data     (data),
    .version  (version),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  sfcb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  sfcb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  // Split the result onto its ports
  assign target         = out_res.target;
  assign out_byte       = out_res.out_byte;
  assign select_release = out_res.select_release;
  assign wants_reply    = out_res.wants_reply;
  assign packet_end     = out_res.packet_end;
  assign exit_request   = out_res.exit_request;
  assign last           = out_res.last;

endmodule

### hw/rtl/sfcb_front.sv
module sfcb_front import sfcb_pkg::*; #(
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [7:0] data,
  input  logic [7:0] version,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  // Byte counter wide enough for a full page and for one chunk size
  localparam int PAGE_W = $clog2(PAGE_BYTES + 1);
  localparam int CL_W   = $clog2(CHUNK_BYTES + 1);
  localparam int REM_W  = (PAGE_W > CL_W) ? PAGE_W : CL_W;
  localparam logic [REM_W-1:0] PAGE_INIT = REM_W'(PAGE_BYTES);
  localparam logic [REM_W-1:0] CHUNK_REM = REM_W'(CHUNK_BYTES);
  localparam logic [CL_W-1:0]  CHUNK_CL  = CL_W'(CHUNK_BYTES);

  // Phase codes
  localparam logic [3:0] PH_COLLECT      = 4'd0;
  localparam logic [3:0] PH_VERSION      = 4'd1;
  localparam logic [3:0] PH_ID_TICK      = 4'd2;
  localparam logic [3:0] PH_ID_REPLY     = 4'd3;
  localparam logic [3:0] PH_WRITE        = 4'd4;
  localparam logic [3:0] PH_READ_TICK    = 4'd5;
  localparam logic [3:0] PH_READ_REPLY   = 4'd6;
  localparam logic [3:0] PH_POLL         = 4'd7;
  localparam logic [3:0] PH_STATUS_TICK  = 4'd8;
  localparam logic [3:0] PH_STATUS_REPLY = 4'd9;
  localparam logic [3:0] PH_SUCCESS      = 4'd10;
  localparam logic [3:0] PH_ERROR        = 4'd11;

  logic [3:0]       phase, phase_next;
  logic [7:0]       cmd0, cmd0_next;
  logic [7:0]       cmd1, cmd1_next;
  logic [7:0]       cmd2, cmd2_next;
  logic [7:0]       cmd3, cmd3_next;
  logic [1:0]       byte_index, byte_index_next;
  logic [REM_W-1:0] remaining, remaining_next;
  logic [7:0]       byte_sum, byte_sum_next;
  logic [2:0]       reply_count, reply_count_next;
  logic [CL_W-1:0]  chunk_left, chunk_left_next;

  logic             accept;
  logic [CL_W-1:0]  chunk_take;
  logic [CL_W-1:0]  chunk_dec;
  logic [REM_W-1:0] rem_after;
  logic [2:0]       rc_inc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Size of the next read chunk and what is left after it
  always_comb begin
    if (remaining < CHUNK_REM) begin
      chunk_take = remaining[CL_W-1:0];
    end else begin
      chunk_take = CHUNK_CL;
    end
    rem_after = remaining - REM_W'(chunk_take);
    chunk_dec = (chunk_left != '0) ? chunk_left - 1'b1 : chunk_left;
    rc_inc    = reply_count + 3'd1;
  end

  // Advance the command state and classify the item into a job
  always_comb begin
    phase_next       = phase;
    cmd0_next        = cmd0;
    cmd1_next        = cmd1;
    cmd2_next        = cmd2;
    cmd3_next        = cmd3;
    byte_index_next  = byte_index;
    remaining_next   = remaining;
    byte_sum_next    = byte_sum;
    reply_count_next = reply_count;
    chunk_left_next  = chunk_left;
    push             = 1'b0;
    push_job         = '0;
    push_job.addr    = {cmd1, cmd2, cmd3};

    if (accept) begin
      case (phase)
        PH_COLLECT: begin
          if (op == OP_HOST) begin
            case (byte_index)
              2'd0: cmd0_next = data;
              2'd1: cmd1_next = data;
              2'd2: cmd2_next = data;
              default: cmd3_next = data;
            endcase
            if (byte_index == 2'd3) begin
              byte_index_next = 2'd0;
              push_job.addr   = {cmd1, cmd2, data};
              case (cmd0)
                OPC_VERSION: phase_next = PH_VERSION;
                OPC_ID:      phase_next = PH_ID_TICK;
                OPC_WRITE: begin
                  phase_next     = PH_WRITE;
                  remaining_next = PAGE_INIT;
                  byte_sum_next  = 8'h00;
                  push           = 1'b1;
                  push_job.kind  = J_WHDR;
                end
                OPC_READ: begin
                  phase_next     = PH_READ_TICK;
                  remaining_next = PAGE_INIT;
                  push           = 1'b1;
                  push_job.kind  = J_RHDR;
                end
                OPC_ERASE: begin
                  phase_next    = PH_POLL;
                  push          = 1'b1;
                  push_job.kind = J_ERASE;
                end
                OPC_STATUS: phase_next = PH_STATUS_TICK;
                OPC_BOOT: begin
                  push          = 1'b1;
                  push_job.kind = J_EXIT;
                  push_job.data = {6'd0, EXIT_BOOT};
                end
                OPC_NORMAL: begin
                  push          = 1'b1;
                  push_job.kind = J_EXIT;
                  push_job.data = {6'd0, EXIT_NORMAL};
                end
                default: phase_next = PH_ERROR;
              endcase
            end else begin
              byte_index_next = byte_index + 2'd1;
            end
          end
        end
        PH_WRITE: begin
          if (op == OP_HOST) begin
            if (remaining != '0) begin
              push           = 1'b1;
              push_job.kind  = J_WDATA;
              push_job.data  = data;
              push_job.rel   = (remaining == REM_W'(1));
              byte_sum_next  = byte_sum + data;
              remaining_next = remaining - 1'b1;
            end else if ((~byte_sum + 8'd1) == data) begin
              push          = 1'b1;
              push_job.kind = J_PROG;
              phase_next    = PH_POLL;
            end else begin
              phase_next = PH_ERROR;
            end
          end
        end
        PH_VERSION: begin
          if (op == OP_TICK) begin
            push          = 1'b1;
            push_job.kind = J_VERSION;
            push_job.data = version;
            phase_next    = PH_COLLECT;
          end
        end
        PH_ID_TICK: begin
          if (op == OP_TICK) begin
            push             = 1'b1;
            push_job.kind    = J_ID;
            reply_count_next = 3'd0;
            phase_next       = PH_ID_REPLY;
          end
        end
        PH_ID_REPLY: begin
          if (op == OP_FLASH) begin
            push          = 1'b1;
            push_job.kind = J_HOST;
            push_job.data = data;
            if (rc_inc >= 3'd4) begin
              push_job.pend    = 1'b1;
              reply_count_next = 3'd0;
              phase_next       = PH_COLLECT;
            end else begin
              reply_count_next = rc_inc;
            end
          end
        end
        PH_READ_TICK: begin
          if (op == OP_TICK) begin
            if (chunk_take == '0) begin
              phase_next = PH_COLLECT;
            end else begin
              chunk_left_next = chunk_take;
              remaining_next  = rem_after;
              push            = 1'b1;
              push_job.kind   = J_RFIRST;
              push_job.rel    = (chunk_take == CL_W'(1)) && (rem_after == '0);
              phase_next      = PH_READ_REPLY;
            end
          end
        end
        PH_READ_REPLY: begin
          if (op == OP_FLASH) begin
            chunk_left_next = chunk_dec;
            push            = 1'b1;
            push_job.data   = data;
            if (chunk_dec == '0) begin
              push_job.kind = J_HOST;
              push_job.pend = 1'b1;
              phase_next    = (remaining == '0) ? PH_COLLECT : PH_READ_TICK;
            end else begin
              push_job.kind = J_RMID;
              push_job.rel  = (chunk_dec == CL_W'(1)) && (remaining == '0);
            end
          end
        end
        PH_POLL: begin
          if (op == OP_FLASH) begin
            if (data[7]) begin
              phase_next = PH_SUCCESS;
            end else begin
              push          = 1'b1;
              push_job.kind = J_POLL;
            end
          end
        end
        PH_STATUS_TICK: begin
          if (op == OP_TICK) begin
            push          = 1'b1;
            push_job.kind = J_POLL;
            phase_next    = PH_STATUS_REPLY;
          end
        end
        PH_STATUS_REPLY: begin
          if (op == OP_FLASH) begin
            push          = 1'b1;
            push_job.kind = J_HOST;
            push_job.data = data;
            push_job.pend = 1'b1;
            phase_next    = PH_COLLECT;
          end
        end
        PH_SUCCESS, PH_ERROR: begin
          if (op == OP_TICK) begin
            push          = 1'b1;
            push_job.kind = J_HOST;
            push_job.data = (phase == PH_SUCCESS) ? 8'h01 : 8'h00;
            push_job.pend = 1'b1;
            phase_next    = PH_COLLECT;
          end
        end
        default: phase_next = PH_COLLECT;
      endcase
    end
  end

  // Hold the command state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_COLLECT;
      cmd0        <= 8'h00;
      cmd1        <= 8'h00;
      cmd2        <= 8'h00;
      cmd3        <= 8'h00;
      byte_index  <= 2'd0;
      remaining   <= '0;
      byte_sum    <= 8'h00;
      reply_count <= 3'd0;
      chunk_left  <= '0;
    end else begin
      phase       <= phase_next;
      cmd0        <= cmd0_next;
      cmd1        <= cmd1_next;
      cmd2        <= cmd2_next;
      cmd3        <= cmd3_next;
      byte_index  <= byte_index_next;
      remaining   <= remaining_next;
      byte_sum    <= byte_sum_next;
      reply_count <= reply_count_next;
      chunk_left  <= chunk_left_next;
    end
  end

endmodule

### hw/rtl/sfcb_queue.sv
module sfcb_queue import sfcb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  job_t             entries [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/sfcb_back.sv
module sfcb_back import sfcb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  input  job_t head_job,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic [2:0] idx;
  res_t       cur;
  logic       load;

  assign cur  = job_result(head_job, idx);
  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && cur.last;

  // Step through the results of the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= cur.last ? 3'd0 : idx + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result until transferred
  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= cur;
    end
  end

endmodule
